// File: hdl/pmormq_pkg.sv
package pmormq_pkg;

  localparam int BLOCK_LEN_DEF = 8;
  localparam int MAX_ITEMS_DEF = 4096;

  localparam int VAL_W = 32;
  localparam int IDX_W = 12;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic q_load;
    logic div1;
    logic div2;
    logic blk_rd;
    logic blk_sel;
    logic walk_load;
    logic walk_step;
    logic scan_issue;
    logic out_load;
    logic out_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic q_bad;
    logic same_blk;
    logic adj_blk;
    logic walk_end;
    logic scan_end;
  } sts_t;

  // Clamps a widened value to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat_val(logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > $signed({2'b00, {(VAL_W-1){1'b1}}})) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < $signed({2'b11, {(VAL_W-1){1'b0}}})) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/pmormq_ram.sv
module pmormq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/pmormq_ctrl.sv
module pmormq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               kind_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pmormq_pkg::cmd_t   cmd_o,
  input  pmormq_pkg::sts_t   sts_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2  = 4'd2;
  localparam logic [3:0] S_RDA   = 4'd3;
  localparam logic [3:0] S_LOADA = 4'd4;
  localparam logic [3:0] S_STEPA = 4'd5;
  localparam logic [3:0] S_RDB   = 4'd6;
  localparam logic [3:0] S_LOADB = 4'd7;
  localparam logic [3:0] S_STEPB = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       err_q, err_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == pmormq_pkg::KIND_APPEND) begin
            if (sts_i.full) begin
              err_d   = 1'b1;
              state_d = S_OUT;
            end else begin
              cmd_o.append = 1'b1;
            end
          end else begin
            if (sts_i.q_bad) begin
              err_d   = 1'b1;
              state_d = S_OUT;
            end else begin
              err_d        = 1'b0;
              cmd_o.q_load = 1'b1;
              state_d      = S_DIV1;
            end
          end
        end
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = S_RDA;
      end
      S_RDA: begin
        cmd_o.blk_rd = 1'b1;
        state_d      = S_LOADA;
      end
      S_LOADA: begin
        cmd_o.walk_load = 1'b1;
        state_d         = S_STEPA;
      end
      S_STEPA: begin
        if (!sts_i.walk_end) begin
          cmd_o.walk_step = 1'b1;
        end else if (sts_i.same_blk) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        cmd_o.blk_rd  = 1'b1;
        cmd_o.blk_sel = 1'b1;
        state_d       = S_LOADB;
      end
      S_LOADB: begin
        cmd_o.blk_sel   = 1'b1;
        cmd_o.walk_load = 1'b1;
        state_d         = S_STEPB;
      end
      S_STEPB: begin
        cmd_o.blk_sel = 1'b1;
        if (!sts_i.walk_end) begin
          cmd_o.walk_step = 1'b1;
        end else if (sts_i.adj_blk) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_end) begin
          cmd_o.scan_issue = 1'b1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = err_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/pmormq_dp.sv
module pmormq_dp #(
  parameter int BLOCK_LEN = pmormq_pkg::BLOCK_LEN_DEF,
  parameter int MAX_ITEMS = pmormq_pkg::MAX_ITEMS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pmormq_pkg::cmd_t                        cmd_i,
  output pmormq_pkg::sts_t                        sts_o,
  input  logic signed [pmormq_pkg::VAL_W-1:0]     value_i,
  input  logic [pmormq_pkg::IDX_W-1:0]            left_index_i,
  input  logic [pmormq_pkg::IDX_W-1:0]            right_index_i,
  output logic signed [pmormq_pkg::VAL_W-1:0]     minimum_o,
  output logic                                    error_o
);

  localparam int VW       = pmormq_pkg::VAL_W;
  localparam int IW       = pmormq_pkg::IDX_W;
  localparam int AW       = VW + 1;
  localparam int NB       = (MAX_ITEMS + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int BW       = (NB > 1) ? $clog2(NB) : 1;
  localparam int PW       = $clog2(BLOCK_LEN);
  localparam int SW       = BLOCK_LEN - 1;
  localparam int CW       = $clog2(MAX_ITEMS + 1);
  localparam int CmpW     = (CW > IW) ? CW : IW;
  localparam int DivShift = IW + $clog2(BLOCK_LEN);
  localparam int DivRecip = ((1 << DivShift) + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam int ProdW    = IW + DivShift;
  localparam logic signed [AW-1:0] AccInit = {1'b0, {VW{1'b1}}};

  // Append side.
  logic [CW-1:0]           count_q;
  logic [PW-1:0]           bpos_q;
  logic [BW-1:0]           bnum_q;
  logic signed [VW-1:0]    last_q;
  logic [SW-1:0]           steps_q, steps_d;
  logic signed [AW-1:0]    rebuilt_q, rebuilt_d;
  logic signed [AW-1:0]    bmin_q, bmin_d;
  logic                    first_pos, last_pos, up;

  // Query side.
  logic [IW-1:0]           li_q, ri_q;
  logic [ProdW-1:0]        prod_l_q, prod_r_q;
  logic [IW-1:0]           ql, qr, rl, rr, qlc, qrc, rlc, rrc;
  logic [BW-1:0]           lb_q, rb_q, scan_q;
  logic [PW-1:0]           lp_q, rp_q;
  logic                    same_q, adj_q, pend_q;
  logic signed [AW-1:0]    v_q, v_d;
  logic [PW-1:0]           p_q, p_d;
  logic [SW-1:0]           wsteps_q;
  logic [PW-1:0]           lo, hi;
  logic                    step_up;
  logic signed [AW-1:0]    acc_q, acc_d;
  logic signed [VW-1:0]    min_res_q;
  logic                    err_res_q;

  logic signed [VW-1:0]    base_rd, bmin_rd;
  logic [SW-1:0]           step_rd;
  logic [BW-1:0]           blk_addr;

  assign first_pos = (bpos_q == '0);
  assign last_pos  = (bpos_q == PW'(BLOCK_LEN - 1));
  assign up        = (last_q < value_i);

  always_comb begin
    if (first_pos) begin
      rebuilt_d = AW'(value_i);
      steps_d   = '0;
      bmin_d    = AW'(value_i);
    end else begin
      rebuilt_d = up ? rebuilt_q + AW'(1) : rebuilt_q - AW'(1);
      steps_d   = steps_q | (SW'(up) << (bpos_q - PW'(1)));
      bmin_d    = (rebuilt_d < bmin_q) ? rebuilt_d : bmin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bpos_q  <= '0;
      bnum_q  <= '0;
      last_q  <= '0;
    end else if (cmd_i.append) begin
      count_q <= count_q + CW'(1);
      last_q  <= value_i;
      if (last_pos) begin
        bpos_q <= '0;
        bnum_q <= bnum_q + BW'(1);
      end else begin
        bpos_q <= bpos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      steps_q   <= steps_d;
      rebuilt_q <= rebuilt_d;
      bmin_q    <= bmin_d;
    end
  end

  // Block index and position of each query bound, by reciprocal multiply.
  always_comb begin
    ql  = IW'(prod_l_q >> DivShift);
    qr  = IW'(prod_r_q >> DivShift);
    rl  = li_q - IW'(ql * BLOCK_LEN);
    rr  = ri_q - IW'(qr * BLOCK_LEN);
    qlc = ql;
    rlc = rl;
    qrc = qr;
    rrc = rr;
    if (rl >= IW'(BLOCK_LEN)) begin
      qlc = ql + IW'(1);
      rlc = rl - IW'(BLOCK_LEN);
    end
    if (rr >= IW'(BLOCK_LEN)) begin
      qrc = qr + IW'(1);
      rrc = rr - IW'(BLOCK_LEN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      li_q <= left_index_i;
      ri_q <= right_index_i;
    end
    if (cmd_i.div1) begin
      prod_l_q <= ProdW'(li_q) * ProdW'(DivRecip);
      prod_r_q <= ProdW'(ri_q) * ProdW'(DivRecip);
    end
    if (cmd_i.div2) begin
      lb_q   <= qlc[BW-1:0];
      rb_q   <= qrc[BW-1:0];
      lp_q   <= rlc[PW-1:0];
      rp_q   <= rrc[PW-1:0];
      same_q <= (qlc == qrc);
      adj_q  <= (qlc + IW'(1) == qrc);
      scan_q <= qlc[BW-1:0] + BW'(1);
    end else if (cmd_i.scan_issue) begin
      scan_q <= scan_q + BW'(1);
    end
  end

  // Walk over the step bits of one block.
  assign lo      = cmd_i.blk_sel ? '0 : lp_q;
  assign hi      = (cmd_i.blk_sel || same_q) ? rp_q : PW'(BLOCK_LEN - 1);
  assign step_up = |(wsteps_q & (SW'(1) << p_q));

  always_comb begin
    v_d   = v_q;
    p_d   = p_q;
    acc_d = acc_q;
    if (cmd_i.q_load) begin
      acc_d = AccInit;
    end else if (cmd_i.walk_load) begin
      v_d = AW'(base_rd);
      p_d = '0;
      if (lo == '0 && v_d < acc_q) begin
        acc_d = v_d;
      end
    end else if (cmd_i.walk_step) begin
      v_d = step_up ? v_q + AW'(1) : v_q - AW'(1);
      p_d = p_q + PW'(1);
      if (p_d >= lo && v_d < acc_q) begin
        acc_d = v_d;
      end
    end else if (pend_q) begin
      if (AW'(bmin_rd) < acc_q) begin
        acc_d = AW'(bmin_rd);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    p_q   <= p_d;
    acc_q <= acc_d;
    if (cmd_i.walk_load) begin
      wsteps_q <= step_rd;
    end
    if (cmd_i.out_load) begin
      min_res_q <= cmd_i.out_err ? '0 : pmormq_pkg::sat_val(acc_q);
      err_res_q <= cmd_i.out_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan_issue;
    end
  end

  assign blk_addr = cmd_i.blk_sel ? rb_q : lb_q;

  pmormq_ram #(.WIDTH(VW), .DEPTH(NB)) u_base_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.append & first_pos),
    .wr_addr_i (bnum_q),
    .wr_data_i (value_i),
    .rd_en_i   (cmd_i.blk_rd),
    .rd_addr_i (blk_addr),
    .rd_data_o (base_rd)
  );

  pmormq_ram #(.WIDTH(SW), .DEPTH(NB)) u_step_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.append),
    .wr_addr_i (bnum_q),
    .wr_data_i (steps_d),
    .rd_en_i   (cmd_i.blk_rd),
    .rd_addr_i (blk_addr),
    .rd_data_o (step_rd)
  );

  pmormq_ram #(.WIDTH(VW), .DEPTH(NB)) u_bmin_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.append & last_pos),
    .wr_addr_i (bnum_q),
    .wr_data_i (pmormq_pkg::sat_val(bmin_d)),
    .rd_en_i   (cmd_i.scan_issue),
    .rd_addr_i (scan_q),
    .rd_data_o (bmin_rd)
  );

  assign sts_o.full     = (count_q == CW'(MAX_ITEMS));
  assign sts_o.q_bad    = (left_index_i > right_index_i) ||
                          (CmpW'(right_index_i) >= CmpW'(count_q));
  assign sts_o.same_blk = same_q;
  assign sts_o.adj_blk  = adj_q;
  assign sts_o.walk_end = (p_q == hi);
  assign sts_o.scan_end = (scan_q == rb_q);

  assign minimum_o = min_res_q;
  assign error_o   = err_res_q;

endmodule

// File: hdl/plus_minus_one_range_min_query_unit.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | kind_i, value_i, left_index_i, right_index_i
// out     | output    | out_valid_o / out_stall_i| minimum_o, error_o
//
// An append item leaves the controller idle and gives no result unless the store is full.
// A query within one block takes longer the later its last queried position r lies;
// across blocks it also walks the whole left block and then the right block up to r,
// and scans the n whole blocks that lie between the bounds, if n > 0:
// the in-block walk moves one step bit per cycle and the block-minima memory is read
// through one port, one block a cycle.
// Reset is asynchronous and active low; the memories need no clearing pass.
// An item is taken only when the controller is idle; a waiting result in the output
// register does not hold back appends, only the next result.

module plus_minus_one_range_min_query_unit #(
  parameter int BLOCK_LEN = pmormq_pkg::BLOCK_LEN_DEF,
  parameter int MAX_ITEMS = pmormq_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [pmormq_pkg::VAL_W-1:0] value_i,
  input  logic [pmormq_pkg::IDX_W-1:0]        left_index_i,
  input  logic [pmormq_pkg::IDX_W-1:0]        right_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pmormq_pkg::VAL_W-1:0] minimum_o,
  output logic                                error_o
);

  // The controller sequences each query: index split, one or two partial block
  // walks, then a scan over the recorded minima of any whole blocks in between.
  pmormq_pkg::cmd_t cmd;
  pmormq_pkg::sts_t sts;

  pmormq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the block records, the running block minimum built
  // during appends, and the accumulator of the query minimum.
  pmormq_dp #(
    .BLOCK_LEN (BLOCK_LEN),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .minimum_o     (minimum_o),
    .error_o       (error_o)
  );

endmodule

// File: hdl/pmormq_chk.sv
module pmormq_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                kind_i,
  input logic signed [pmormq_pkg::VAL_W-1:0] value_i,
  input logic [pmormq_pkg::IDX_W-1:0]        left_index_i,
  input logic [pmormq_pkg::IDX_W-1:0]        right_index_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [pmormq_pkg::VAL_W-1:0] minimum_o,
  input logic                                error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(minimum_o) && $stable(error_o))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> minimum_o == '0)
    else $error("flagged result carries a minimum");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == pmormq_pkg::KIND_QUERY |=> in_stall_o)
    else $error("query accepted without the unit going busy");

endmodule

bind plus_minus_one_range_min_query_unit pmormq_chk u_chk (.*);
